// File: hw/rtl/key_value_line_parser_unit_defines.svh
// assertion macros for the key/value line parser, used by the emitter
`ifndef KEY_VALUE_LINE_PARSER_UNIT_DEFINES_SVH
`define KEY_VALUE_LINE_PARSER_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clock, off while reset is high
`define KVLP_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("kvlp: same-cycle check failed");

// next-cycle implication, sampled on clock, off while reset is high
`define KVLP_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("kvlp: next-cycle check failed");

`endif

// File: hw/rtl/kvlp_pkg.sv
// shared constants and types of the key/value line parser
package kvlp_pkg;

   // default sizes
   localparam int KVLP_LINE_BYTES  = 128;
   localparam int KVLP_STORE_BYTES = 4096;

   // largest supported line store, sets the width of shared fields
   localparam int KVLP_LINE_MAX = 256;
   localparam int KVLP_ADDR_W   = $clog2(KVLP_LINE_MAX);
   localparam int KVLP_SPAN_W   = KVLP_ADDR_W + 1;

   // record limit of the packed table
   localparam int KVLP_RECORD_MAX = 255;

   // request op codes
   localparam logic OP_TEXT = 1'b0;
   localparam logic OP_END  = 1'b1;

   // character codes
   localparam logic [7:0] CHAR_HASH  = 8'h23;
   localparam logic [7:0] CHAR_EQ    = 8'h3D;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_SPACE = 8'h20;

   // line store write from the parser
   typedef struct packed {
      logic                   en;
      logic [KVLP_ADDR_W-1:0] addr;
      logic [7:0]             data;
   } store_wr_type;

   // record hand-off from the parser to the emitter
   typedef struct packed {
      logic                   go;
      logic                   restart;
      logic [KVLP_SPAN_W-1:0] key_begin;
      logic [KVLP_SPAN_W-1:0] key_finish;
      logic [KVLP_SPAN_W-1:0] value_begin;
      logic [KVLP_SPAN_W-1:0] value_finish;
   } record_req_type;

endpackage

// File: hw/rtl/kvlp_req_if.sv
// request channel of the key/value line parser
interface kvlp_req_if;
   logic       valid;
   logic       ready;
   logic       op;
   logic [7:0] in_byte;

   modport source (output valid, output op, output in_byte, input ready);
   modport sink   (input valid, input op, input in_byte, output ready);
endinterface

// File: hw/rtl/kvlp_rsp_if.sv
// result channel of the key/value line parser
interface kvlp_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  out_byte0;
   logic [7:0]  out_byte1;
   logic [7:0]  out_byte2;
   logic [7:0]  out_byte3;
   logic [2:0]  byte_count;
   logic        last;
   logic [7:0]  record_number;
   logic [11:0] store_offset;

   modport source (output valid, output out_byte0, output out_byte1, output out_byte2,
                   output out_byte3, output byte_count, output last, output record_number,
                   output store_offset, input ready);
   modport sink   (input valid, input out_byte0, input out_byte1, input out_byte2,
                   input out_byte3, input byte_count, input last, input record_number,
                   input store_offset, output ready);
endinterface

// File: hw/rtl/kvlp_parser.sv
// per-byte line parser: start, comment, key and value modes
module kvlp_parser import kvlp_pkg::*; #(
   parameter int LINE_BYTES = KVLP_LINE_BYTES
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           idle,
   kvlp_req_if.sink       req_ch,
   output store_wr_type   store_wr,
   output record_req_type record_req
);

   localparam int AW = $clog2(LINE_BYTES);
   localparam logic [AW-1:0] LAST_POS = AW'(LINE_BYTES - 1);

   typedef enum logic [3:0] {
      MODE_START   = 4'b0001,
      MODE_COMMENT = 4'b0010,
      MODE_KEY     = 4'b0100,
      MODE_VALUE   = 4'b1000
   } parse_mode_type;

   parse_mode_type mode_ff, mode_in;
   logic [AW-1:0]  line_pos_ff, line_pos_in;
   logic [AW-1:0]  kb_ff, kb_in;
   logic [AW-1:0]  kf_ff, kf_in;
   logic [AW:0]    vb_ff, vb_in;
   logic [AW-1:0]  vf_ff, vf_in;

   logic       accept;
   logic       restart_only;
   logic [7:0] ch;
   logic       eol;
   logic       blank;

   // request handshake and character decode
   assign req_ch.ready = idle;
   assign accept       = req_ch.valid && req_ch.ready;
   assign restart_only = (req_ch.op == OP_END) && (line_pos_ff == '0);
   assign ch           = (req_ch.op == OP_END) ? CHAR_LF : req_ch.in_byte;
   assign eol          = (ch == CHAR_LF) || (ch == CHAR_CR);
   assign blank        = (ch == CHAR_SPACE) || (ch == CHAR_TAB);

   // every text byte lands in the line store at the current position
   assign store_wr.en   = accept && !restart_only;
   assign store_wr.addr = KVLP_ADDR_W'(line_pos_ff);
   assign store_wr.data = ch;

   // mode machine and span marks
   always_comb begin
      logic          line_end;
      logic          emit;
      logic [AW-1:0] vf_mark;
      mode_in     = mode_ff;
      line_pos_in = line_pos_ff;
      kb_in       = kb_ff;
      kf_in       = kf_ff;
      vb_in       = vb_ff;
      vf_in       = vf_ff;
      line_end    = 1'b0;
      emit        = 1'b0;
      vf_mark     = vf_ff;
      record_req  = '0;
      if (accept && restart_only) begin
         mode_in     = MODE_START;
         line_pos_in = '0;
         kb_in       = '0;
         kf_in       = '0;
         vb_in       = '0;
         vf_in       = '0;
         record_req.restart = 1'b1;
      end else if (accept) begin
         case (mode_ff)
            MODE_START: begin
               if (eol) begin
                  line_end = 1'b1;
               end else if (blank) begin
                  mode_in = MODE_START;
               end else if (ch == CHAR_HASH) begin
                  mode_in = MODE_COMMENT;
               end else begin
                  mode_in = MODE_KEY;
                  kb_in   = line_pos_ff;
               end
            end
            MODE_COMMENT: begin
               if (eol) begin
                  emit     = (vf_ff != '0);
                  line_end = 1'b1;
               end
            end
            MODE_KEY: begin
               if (ch == CHAR_EQ) begin
                  mode_in = MODE_VALUE;
                  kf_in   = line_pos_ff;
                  vb_in   = {1'b0, line_pos_ff} + (AW+1)'(1);
               end else if (eol) begin
                  line_end = 1'b1;
               end else if (ch == CHAR_HASH) begin
                  kb_in   = '0;
                  kf_in   = '0;
                  mode_in = MODE_COMMENT;
               end
            end
            MODE_VALUE: begin
               if (eol) begin
                  vf_mark  = (vf_ff == '0) ? line_pos_ff : vf_ff;
                  emit     = 1'b1;
                  line_end = 1'b1;
               end else if (ch == CHAR_HASH) begin
                  if (vf_ff == '0) begin
                     vf_in = line_pos_ff;
                  end
                  mode_in = MODE_COMMENT;
               end
            end
            default: begin
               mode_in = MODE_START;
            end
         endcase

         // next line starts at position one, long lines stick at the end
         if (line_end) begin
            mode_in     = MODE_START;
            line_pos_in = AW'(1);
            kb_in       = '0;
            kf_in       = '0;
            vb_in       = '0;
            vf_in       = '0;
         end else begin
            line_pos_in = (line_pos_ff == LAST_POS) ? LAST_POS : line_pos_ff + AW'(1);
         end

         // end of input: implicit newline above, then back to reset values
         if (req_ch.op == OP_END) begin
            mode_in     = MODE_START;
            line_pos_in = '0;
            kb_in       = '0;
            kf_in       = '0;
            vb_in       = '0;
            vf_in       = '0;
            record_req.restart = 1'b1;
         end

         record_req.go           = emit;
         record_req.key_begin    = KVLP_SPAN_W'(kb_ff);
         record_req.key_finish   = KVLP_SPAN_W'(kf_ff);
         record_req.value_begin  = KVLP_SPAN_W'(vb_ff);
         record_req.value_finish = KVLP_SPAN_W'(vf_mark);
      end
   end

   // parser registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_START;
         line_pos_ff <= '0;
         kb_ff       <= '0;
         kf_ff       <= '0;
         vb_ff       <= '0;
         vf_ff       <= '0;
      end else begin
         mode_ff     <= mode_in;
         line_pos_ff <= line_pos_in;
         kb_ff       <= kb_in;
         kf_ff       <= kf_in;
         vb_ff       <= vb_in;
         vf_ff       <= vf_in;
      end
   end

endmodule

// File: hw/rtl/kvlp_emitter.sv
// line store, trim sequencer and record packer with output register
`include "key_value_line_parser_unit_defines.svh"

module kvlp_emitter import kvlp_pkg::*; #(
   parameter int LINE_BYTES  = KVLP_LINE_BYTES,
   parameter int STORE_BYTES = KVLP_STORE_BYTES
) (
   input  logic           clock,
   input  logic           reset,
   input  store_wr_type   store_wr,
   input  record_req_type record_req,
   output logic           idle,
   kvlp_rsp_if.source     rsp_ch
);

   localparam int AW   = $clog2(LINE_BYTES);
   localparam int SPW  = AW + 1;
   localparam int SW   = $clog2(STORE_BYTES);
   localparam int SUMW = ((SW > SPW + 1) ? SW : SPW + 1) + 1;

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_LEAD   = 6'b000010,
      ST_TRAIL  = 6'b000100,
      ST_SIZE   = 6'b001000,
      ST_STREAM = 6'b010000,
      ST_FINISH = 6'b100000
   } emit_state_type;

   typedef enum logic [5:0] {
      PH_KLEN  = 6'b000001,
      PH_KEY   = 6'b000010,
      PH_KZERO = 6'b000100,
      PH_VLEN  = 6'b001000,
      PH_VAL   = 6'b010000,
      PH_VZERO = 6'b100000
   } emit_phase_type;

   // line store
   logic [7:0]    store_mem [LINE_BYTES];
   logic [7:0]    rd_data_ff;
   logic          rd_en;
   logic [AW-1:0] rd_addr;

   emit_state_type state_ff, state_in;
   emit_phase_type phase_ff, phase_in;
   logic           span_val_ff, span_val_in;
   logic           rd_wait_ff, rd_wait_in;
   logic           restart_ff, restart_in;
   logic [SPW-1:0] cur_s_ff, cur_s_in;
   logic [SPW-1:0] cur_f_ff, cur_f_in;
   logic [SPW-1:0] ks_ff, ks_in;
   logic [SPW-1:0] kf_ff, kf_in;
   logic [SPW-1:0] vs_ff, vs_in;
   logic [SPW-1:0] vf_ff, vf_in;
   logic [SPW-1:0] klen_ff, klen_in;
   logic [SPW-1:0] vlen_ff, vlen_in;
   logic [SPW-1:0] ptr_ff, ptr_in;
   logic [SPW-1:0] rem_ff, rem_in;
   logic [7:0]     buf_ff [3];
   logic [7:0]     buf_in [3];
   logic [1:0]     cnt_ff, cnt_in;
   logic [SW-1:0]  chunk_off_ff, chunk_off_in;
   logic [SW-1:0]  pos_ff, pos_in;
   logic [7:0]     total_ff, total_in;

   // output register
   logic        out_valid_ff, out_valid_in;
   logic [7:0]  out_b0_ff, out_b0_in;
   logic [7:0]  out_b1_ff, out_b1_in;
   logic [7:0]  out_b2_ff, out_b2_in;
   logic [7:0]  out_b3_ff, out_b3_in;
   logic [2:0]  out_cnt_ff, out_cnt_in;
   logic        out_last_ff, out_last_in;
   logic [7:0]  out_num_ff, out_num_in;
   logic [11:0] out_off_ff, out_off_in;

   logic           can_push;
   logic           is_space;
   logic [SPW-1:0] f_dec;
   logic [SPW:0]   s_inc;
   logic [SPW-1:0] klen_now;
   logic [SPW-1:0] vlen_now;
   logic [SUMW-1:0] len_sum;
   logic           drop;
   logic           push;

   assign idle     = (state_ff == ST_IDLE);
   assign can_push = !out_valid_ff || rsp_ch.ready;
   assign is_space = (rd_data_ff == CHAR_SPACE);
   assign f_dec    = cur_f_ff - SPW'(1);
   assign s_inc    = {1'b0, cur_s_ff} + (SPW+1)'(1);

   // trimmed lengths and the table-full check
   assign klen_now = (kf_ff > ks_ff) ? kf_ff - ks_ff : '0;
   assign vlen_now = (vf_ff > vs_ff) ? vf_ff - vs_ff : '0;
   assign len_sum  = SUMW'(pos_ff) + SUMW'(klen_now) + SUMW'(vlen_now) + SUMW'(4);
   assign drop     = (len_sum >= SUMW'(STORE_BYTES)) || (total_ff >= 8'(KVLP_RECORD_MAX));

   // line store write port and registered read port
   always_ff @(posedge clock) begin
      if (store_wr.en) begin
         store_mem[store_wr.addr[AW-1:0]] <= store_wr.data;
      end
      if (rd_en) begin
         rd_data_ff <= store_mem[rd_addr];
      end
   end

   // sequencer
   always_comb begin
      logic          span_done;
      logic          produce;
      logic          blast;
      logic          completes;
      logic          commit;
      logic [7:0]    bval;
      logic [SPW:0]  len_inc;
      logic [SW-1:0] off_now;
      state_in     = state_ff;
      phase_in     = phase_ff;
      span_val_in  = span_val_ff;
      rd_wait_in   = rd_wait_ff;
      restart_in   = restart_ff;
      cur_s_in     = cur_s_ff;
      cur_f_in     = cur_f_ff;
      ks_in        = ks_ff;
      kf_in        = kf_ff;
      vs_in        = vs_ff;
      vf_in        = vf_ff;
      klen_in      = klen_ff;
      vlen_in      = vlen_ff;
      ptr_in       = ptr_ff;
      rem_in       = rem_ff;
      buf_in       = buf_ff;
      cnt_in       = cnt_ff;
      chunk_off_in = chunk_off_ff;
      pos_in       = pos_ff;
      total_in     = total_ff;
      out_valid_in = out_valid_ff;
      out_b0_in    = out_b0_ff;
      out_b1_in    = out_b1_ff;
      out_b2_in    = out_b2_ff;
      out_b3_in    = out_b3_ff;
      out_cnt_in   = out_cnt_ff;
      out_last_in  = out_last_ff;
      out_num_in   = out_num_ff;
      out_off_in   = out_off_ff;
      rd_en        = 1'b0;
      rd_addr      = cur_s_ff[AW-1:0];
      span_done    = 1'b0;
      produce      = 1'b0;
      blast        = 1'b0;
      completes    = 1'b0;
      commit       = 1'b0;
      bval         = '0;
      len_inc      = '0;
      off_now      = '0;
      push         = 1'b0;

      // result taken by the receiver
      if (out_valid_ff && rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (record_req.go) begin
               cur_s_in    = record_req.key_begin[SPW-1:0];
               cur_f_in    = record_req.key_finish[SPW-1:0];
               vs_in       = record_req.value_begin[SPW-1:0];
               vf_in       = record_req.value_finish[SPW-1:0];
               restart_in  = record_req.restart;
               span_val_in = 1'b0;
               rd_wait_in  = 1'b0;
               state_in    = ST_LEAD;
            end else if (record_req.restart) begin
               pos_in   = SW'(1);
               total_in = '0;
            end
         end
         // strip leading spaces, one store read per step
         ST_LEAD: begin
            if (!rd_wait_ff) begin
               if (cur_s_ff < cur_f_ff) begin
                  rd_en      = 1'b1;
                  rd_addr    = cur_s_ff[AW-1:0];
                  rd_wait_in = 1'b1;
               end else begin
                  state_in = ST_TRAIL;
               end
            end else begin
               rd_wait_in = 1'b0;
               if (is_space) begin
                  cur_s_in = cur_s_ff + SPW'(1);
               end else begin
                  state_in = ST_TRAIL;
               end
            end
         end
         // strip trailing spaces, keeping at least one byte
         ST_TRAIL: begin
            if (!rd_wait_ff) begin
               if ({1'b0, cur_f_ff} > s_inc) begin
                  rd_en      = 1'b1;
                  rd_addr    = f_dec[AW-1:0];
                  rd_wait_in = 1'b1;
               end else begin
                  span_done = 1'b1;
               end
            end else begin
               rd_wait_in = 1'b0;
               if (is_space) begin
                  cur_f_in = f_dec;
               end else begin
                  span_done = 1'b1;
               end
            end
            if (span_done && !span_val_ff) begin
               ks_in       = cur_s_ff;
               kf_in       = cur_f_ff;
               cur_s_in    = vs_ff;
               cur_f_in    = vf_ff;
               span_val_in = 1'b1;
               state_in    = ST_LEAD;
            end else if (span_done) begin
               vs_in    = cur_s_ff;
               vf_in    = cur_f_ff;
               state_in = ST_SIZE;
            end
         end
         ST_SIZE: begin
            if (drop) begin
               state_in = ST_FINISH;
            end else begin
               total_in   = total_ff + 8'd1;
               klen_in    = klen_now;
               vlen_in    = vlen_now;
               phase_in   = PH_KLEN;
               cnt_in     = '0;
               buf_in[0]  = '0;
               buf_in[1]  = '0;
               buf_in[2]  = '0;
               rd_wait_in = 1'b0;
               state_in   = ST_STREAM;
            end
         end
         // one record byte per step, packed up to four to a result
         ST_STREAM: begin
            case (phase_ff)
               PH_KLEN: begin
                  produce = 1'b1;
                  len_inc = {1'b0, klen_ff} + (SPW+1)'(1);
                  bval    = 8'(len_inc);
               end
               PH_KZERO: begin
                  produce = 1'b1;
               end
               PH_VLEN: begin
                  produce = 1'b1;
                  len_inc = {1'b0, vlen_ff} + (SPW+1)'(1);
                  bval    = 8'(len_inc);
               end
               PH_VZERO: begin
                  produce = 1'b1;
                  blast   = 1'b1;
               end
               PH_KEY, PH_VAL: begin
                  if (!rd_wait_ff) begin
                     rd_en      = 1'b1;
                     rd_addr    = ptr_ff[AW-1:0];
                     rd_wait_in = 1'b1;
                  end else begin
                     produce = 1'b1;
                     bval    = rd_data_ff;
                  end
               end
               default: begin
                  phase_in = PH_KLEN;
               end
            endcase

            completes = (cnt_ff == 2'd3) || blast;
            commit    = produce && (!completes || can_push);
            off_now   = (cnt_ff == 2'd0) ? pos_ff : chunk_off_ff;

            if (commit) begin
               pos_in = pos_ff + SW'(1);
               if (cnt_ff == 2'd0) begin
                  chunk_off_in = pos_ff;
               end

               // advance through the record layout
               case (phase_ff)
                  PH_KLEN: begin
                     ptr_in   = ks_ff;
                     rem_in   = klen_ff;
                     phase_in = (klen_ff == '0) ? PH_KZERO : PH_KEY;
                  end
                  PH_KZERO: begin
                     phase_in = PH_VLEN;
                  end
                  PH_VLEN: begin
                     ptr_in   = vs_ff;
                     rem_in   = vlen_ff;
                     phase_in = (vlen_ff == '0) ? PH_VZERO : PH_VAL;
                  end
                  PH_KEY, PH_VAL: begin
                     rd_wait_in = 1'b0;
                     ptr_in     = ptr_ff + SPW'(1);
                     rem_in     = rem_ff - SPW'(1);
                     if (rem_ff == SPW'(1)) begin
                        phase_in = (phase_ff == PH_KEY) ? PH_KZERO : PH_VZERO;
                     end
                  end
                  default: begin
                     state_in = ST_FINISH;
                  end
               endcase

               if (completes) begin
                  push         = 1'b1;
                  out_valid_in = 1'b1;
                  out_b0_in    = (cnt_ff == 2'd0) ? bval : buf_ff[0];
                  out_b1_in    = (cnt_ff == 2'd1) ? bval : ((cnt_ff > 2'd1) ? buf_ff[1] : 8'd0);
                  out_b2_in    = (cnt_ff == 2'd2) ? bval : ((cnt_ff > 2'd2) ? buf_ff[2] : 8'd0);
                  out_b3_in    = (cnt_ff == 2'd3) ? bval : 8'd0;
                  out_cnt_in   = {1'b0, cnt_ff} + 3'd1;
                  out_last_in  = blast;
                  out_num_in   = total_ff;
                  out_off_in   = 12'(off_now);
                  cnt_in       = '0;
                  buf_in[0]    = '0;
                  buf_in[1]    = '0;
                  buf_in[2]    = '0;
                  if (blast) begin
                     state_in = ST_FINISH;
                  end
               end else begin
                  case (cnt_ff)
                     2'd0: buf_in[0] = bval;
                     2'd1: buf_in[1] = bval;
                     default: buf_in[2] = bval;
                  endcase
                  cnt_in = cnt_ff + 2'd1;
               end
            end
         end
         // end of input puts the table counters back
         ST_FINISH: begin
            if (restart_ff) begin
               pos_in   = SW'(1);
               total_in = '0;
            end
            restart_in = 1'b0;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PH_KLEN;
         span_val_ff  <= 1'b0;
         rd_wait_ff   <= 1'b0;
         restart_ff   <= 1'b0;
         cnt_ff       <= '0;
         pos_ff       <= SW'(1);
         total_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         span_val_ff  <= span_val_in;
         rd_wait_ff   <= rd_wait_in;
         restart_ff   <= restart_in;
         cnt_ff       <= cnt_in;
         pos_ff       <= pos_in;
         total_ff     <= total_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      cur_s_ff     <= cur_s_in;
      cur_f_ff     <= cur_f_in;
      ks_ff        <= ks_in;
      kf_ff        <= kf_in;
      vs_ff        <= vs_in;
      vf_ff        <= vf_in;
      klen_ff      <= klen_in;
      vlen_ff      <= vlen_in;
      ptr_ff       <= ptr_in;
      rem_ff       <= rem_in;
      buf_ff       <= buf_in;
      chunk_off_ff <= chunk_off_in;
      out_b0_ff    <= out_b0_in;
      out_b1_ff    <= out_b1_in;
      out_b2_ff    <= out_b2_in;
      out_b3_ff    <= out_b3_in;
      out_cnt_ff   <= out_cnt_in;
      out_last_ff  <= out_last_in;
      out_num_ff   <= out_num_in;
      out_off_ff   <= out_off_in;
   end

   // result channel
   assign rsp_ch.valid         = out_valid_ff;
   assign rsp_ch.out_byte0     = out_b0_ff;
   assign rsp_ch.out_byte1     = out_b1_ff;
   assign rsp_ch.out_byte2     = out_b2_ff;
   assign rsp_ch.out_byte3     = out_b3_ff;
   assign rsp_ch.byte_count    = out_cnt_ff;
   assign rsp_ch.last          = out_last_ff;
   assign rsp_ch.record_number = out_num_ff;
   assign rsp_ch.store_offset  = out_off_ff;

   // checks
   `KVLP_ASSERT_NOW(a_go_only_when_idle, record_req.go, state_ff == ST_IDLE)
   `KVLP_ASSERT_NOW(a_push_into_free_slot, push, !out_valid_ff || rsp_ch.ready)
   `KVLP_ASSERT_NOW(a_result_fields_sane, out_valid_ff,
      (out_num_ff != 8'd0) && (out_cnt_ff != 3'd0) && (out_cnt_ff <= 3'd4))
   `KVLP_ASSERT_NEXT(a_restart_clears_table, (state_ff == ST_FINISH) && restart_ff,
      (pos_ff == SW'(1)) && (total_ff == 8'd0))

endmodule

// File: hw/rtl/key_value_line_parser_unit.sv
// Key/value configuration line parser, top level.
// Requests on req_ch carry one text byte (op text) or an end-of-input mark
// (op end). Bytes fill a line store; a line end that closes a "key=value" line
// trims both fields of spaces and streams the record on rsp_ch as key length+1,
// key bytes, 0, value length+1, value bytes, 0, up to four bytes per result,
// with last on the final result, the record number and the table offset.
// A plain byte is taken while ready stays high. A line end with a record
// keeps ready low while a sequencer walks the line store through its single
// registered read port: it reads the store for each space trimmed and each
// key or value byte sent, writes length and terminator bytes without a read,
// runs four trim passes, sizes the record and finishes, and waits out receiver
// stalls. Records that would fill the table or pass 255 records give no
// result. End of input behaves as a final newline when the line is not
// empty, then clears state. Reset puts the parser in its start mode with an
// empty table; the line store needs no clearing. A stalled receiver holds
// the result register; the sequencer then waits, and new requests are taken
// once it returns to idle.
module key_value_line_parser_unit import kvlp_pkg::*; #(
   parameter int LINE_BYTES  = KVLP_LINE_BYTES,
   parameter int STORE_BYTES = KVLP_STORE_BYTES
) (
   input logic        clock,
   input logic        reset,
   kvlp_req_if.sink   req_ch,
   kvlp_rsp_if.source rsp_ch
);

   store_wr_type   store_wr;
   record_req_type record_req;
   logic           idle;

   // byte parser
   kvlp_parser #(
      .LINE_BYTES (LINE_BYTES)
   ) u_parser (
      .clock      (clock),
      .reset      (reset),
      .idle       (idle),
      .req_ch     (req_ch),
      .store_wr   (store_wr),
      .record_req (record_req)
   );

   // trim, pack and send
   kvlp_emitter #(
      .LINE_BYTES  (LINE_BYTES),
      .STORE_BYTES (STORE_BYTES)
   ) u_emitter (
      .clock      (clock),
      .reset      (reset),
      .store_wr   (store_wr),
      .record_req (record_req),
      .idle       (idle),
      .rsp_ch     (rsp_ch)
   );

endmodule
